>>> src/rpsc_pkg.sv
// rpsc_pkg: shared types and constants for the redundant pedal sensor check.
// No dependencies; used by rpsc_chan and redundant_pedal_sensor_check.
package rpsc_pkg;

	// Q.8 percent scale: 100 % and the 10-point correlation limit
	localparam logic [14:0] FULL_SCALE_Q8 = 15'd25600;
	localparam logic [14:0] CORR_LIMIT_Q8 = 15'd2560;

	localparam int SPAN_W = 10;
	localparam int GAIN_W = 23;
	localparam int CFG_W  = 23;
	localparam int IDX_W  = 3;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_NORM_LO  = 3'd0;
	localparam logic [IDX_W-1:0] REG_NORM_HI  = 3'd1;
	localparam logic [IDX_W-1:0] REG_NORM_GN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_LO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_HI   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INV_GN   = 3'd5;
	localparam logic [IDX_W-1:0] REG_FAULT_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_FAULT_HI = 3'd7;

	// reset values of the registers
	localparam logic [SPAN_W-1:0] RST_NORM_LO  = 10'd143;
	localparam logic [SPAN_W-1:0] RST_NORM_HI  = 10'd348;
	localparam logic [GAIN_W-1:0] RST_NORM_GN  = 23'd31969;
	localparam logic [SPAN_W-1:0] RST_INV_LO   = 10'd696;
	localparam logic [SPAN_W-1:0] RST_INV_HI   = 10'd900;
	localparam logic [GAIN_W-1:0] RST_INV_GN   = 23'd32000;
	localparam logic [SPAN_W-1:0] RST_FAULT_LO = 10'd102;
	localparam logic [SPAN_W-1:0] RST_FAULT_HI = 10'd921;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NORM_FLT = 2'd1,
		ST_INV_FLT  = 2'd2,
		ST_UNCORR   = 2'd3
	} status_t;

	// load enables for the per-channel pipeline stages
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} pipe_ctl_t;

endpackage

>>> src/rpsc_window.sv
// rpsc_window: sliding window of the last WINDOW samples of one sensor with a
// running sum. Depends on nothing but its parameters.
module rpsc_window #(
	parameter int ADC_BITS = 10,
	parameter int WINDOW   = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [ADC_BITS-1:0]                   wr_data,
	output logic [ADC_BITS+$clog2(WINDOW)-1:0]    sum
);

	localparam int SUMW = ADC_BITS + $clog2(WINDOW);
	localparam int SLW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [ADC_BITS-1:0] samp_q [WINDOW];
	logic [SLW-1:0]      slot_q;
	logic [SUMW-1:0]     sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				samp_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
		end else if (wr_en) begin
			samp_q[slot_q] <= wr_data;
			// new sample in, oldest one out
			sum_q <= sum_q + SUMW'(wr_data) - SUMW'(samp_q[slot_q]);
			if (slot_q == SLW'(WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign sum = sum_q;

endmodule

>>> src/rpsc_chan.sv
// rpsc_chan: per-channel report datapath: window average by reciprocal
// multiply, fault check, span clamp and gain multiply. Uses rpsc_pkg.
module rpsc_chan #(
	parameter int ADC_BITS = 10,
	parameter int WINDOW   = 2
) (
	input  logic                                   clk,
	input  rpsc_pkg::pipe_ctl_t                    ctl,
	input  logic [ADC_BITS+$clog2(WINDOW)-1:0]     sum_s1,
	input  logic [rpsc_pkg::SPAN_W-1:0]            span_lo,
	input  logic [rpsc_pkg::SPAN_W-1:0]            span_hi,
	input  logic [rpsc_pkg::GAIN_W-1:0]            gain,
	input  logic [rpsc_pkg::SPAN_W-1:0]            fault_lo,
	input  logic [rpsc_pkg::SPAN_W-1:0]            fault_hi,
	output logic                                   fault_s3,
	output logic [((ADC_BITS > 10) ? ADC_BITS : 10) + rpsc_pkg::GAIN_W - 9:0] mapped_s3
);

	localparam int SUMW = ADC_BITS + $clog2(WINDOW);
	localparam int DL   = $clog2(WINDOW);
	localparam int SH   = SUMW + DL;
	localparam int PW   = 2 * SUMW + 1;
	localparam int CW   = (ADC_BITS > 10) ? ADC_BITS : 10;
	localparam int GW   = CW + rpsc_pkg::GAIN_W;
	// ceil(2^SH / WINDOW): exact floor division for every SUMW-bit sum
	localparam logic [SUMW:0] RECIP =
		(SUMW + 1)'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic [PW-1:0]       quot_prod;
	logic [ADC_BITS-1:0] avg_s2;
	logic [CW-1:0]       avg_w, lo_w, hi_w, clamp, delta;
	logic [GW-1:0]       gain_prod;
	logic                fault;

	assign quot_prod = PW'(sum_s1) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			avg_s2 <= quot_prod[SH +: ADC_BITS];
		end
	end

	always_comb begin
		avg_w = CW'(avg_s2);
		lo_w  = CW'(span_lo);
		hi_w  = CW'(span_hi);
		fault = (avg_w > CW'(fault_hi)) || (avg_w < CW'(fault_lo));
		if (lo_w <= hi_w) begin
			if (avg_w < lo_w) clamp = lo_w;
			else if (avg_w > hi_w) clamp = hi_w;
			else clamp = avg_w;
			delta = clamp - lo_w;
		end else begin
			// span given high-to-low
			if (avg_w < hi_w) clamp = hi_w;
			else if (avg_w > lo_w) clamp = lo_w;
			else clamp = avg_w;
			delta = lo_w - clamp;
		end
		gain_prod = GW'(delta) * GW'(gain);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			fault_s3  <= fault;
			mapped_s3 <= gain_prod[GW-1:8];
		end
	end

endmodule

>>> src/redundant_pedal_sensor_check.sv
// redundant_pedal_sensor_check: dual pedal sensor plausibility check.
// A report word's result is registered through stages s1 to s4 and is valid once it reaches s4.
// Throughput: one word per cycle, samples and reports alike; a stalled result
// holds the pipeline only when every stage ahead of it is full.
// Reset (arst_n low, async): sample windows, slots and sums to zero,
// registers to defaults, pipeline empty. Uses rpsc_pkg, rpsc_window, rpsc_chan.
module redundant_pedal_sensor_check #(
	parameter int ADC_BITS = 10,
	parameter int WINDOW   = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [rpsc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rpsc_pkg::CFG_W-1:0]    cfg_data,
	// input word channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic                          channel,
	input  logic [ADC_BITS-1:0]           sample,
	// result word channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [14:0]                   position,
	output logic [1:0]                    status
);

	localparam int SUMW = ADC_BITS + $clog2(WINDOW);
	localparam int CW   = (ADC_BITS > 10) ? ADC_BITS : 10;
	localparam int MW   = CW + rpsc_pkg::GAIN_W - 8;
	localparam logic [MW-1:0] FULL_EXT = MW'(rpsc_pkg::FULL_SCALE_Q8);

	// configuration registers
	logic [rpsc_pkg::SPAN_W-1:0] norm_lo_q, norm_hi_q, inv_lo_q, inv_hi_q;
	logic [rpsc_pkg::SPAN_W-1:0] fault_lo_q, fault_hi_q;
	logic [rpsc_pkg::GAIN_W-1:0] norm_gn_q, inv_gn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_lo_q  <= rpsc_pkg::RST_NORM_LO;
			norm_hi_q  <= rpsc_pkg::RST_NORM_HI;
			norm_gn_q  <= rpsc_pkg::RST_NORM_GN;
			inv_lo_q   <= rpsc_pkg::RST_INV_LO;
			inv_hi_q   <= rpsc_pkg::RST_INV_HI;
			inv_gn_q   <= rpsc_pkg::RST_INV_GN;
			fault_lo_q <= rpsc_pkg::RST_FAULT_LO;
			fault_hi_q <= rpsc_pkg::RST_FAULT_HI;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpsc_pkg::REG_NORM_LO:  norm_lo_q  <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				rpsc_pkg::REG_NORM_HI:  norm_hi_q  <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				rpsc_pkg::REG_NORM_GN:  norm_gn_q  <= cfg_data[rpsc_pkg::GAIN_W-1:0];
				rpsc_pkg::REG_INV_LO:   inv_lo_q   <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				rpsc_pkg::REG_INV_HI:   inv_hi_q   <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				rpsc_pkg::REG_INV_GN:   inv_gn_q   <= cfg_data[rpsc_pkg::GAIN_W-1:0];
				rpsc_pkg::REG_FAULT_LO: fault_lo_q <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				rpsc_pkg::REG_FAULT_HI: fault_hi_q <= cfg_data[rpsc_pkg::SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline occupancy. Each stage may load when it is empty or the stage
	// after it is loading, so bubbles collapse under an output stall.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic in_acc;
	rpsc_pkg::pipe_ctl_t ctl;

	assign rdy_s4   = !vld_s4 || !out_stall;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign in_acc   = in_valid && rdy_s1;
	assign ctl      = '{ld_s2: rdy_s2, ld_s3: rdy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_acc && opcode;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// Sample words go straight into the windows; the running sums always
	// reflect the last WINDOW samples accepted on their channel.
	logic [SUMW-1:0] sum_n, sum_i, sum_n_s1, sum_i_s1;

	rpsc_window #(.ADC_BITS(ADC_BITS), .WINDOW(WINDOW)) u_win_n (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc && !opcode && !channel),
		.wr_data (sample),
		.sum     (sum_n)
	);

	rpsc_window #(.ADC_BITS(ADC_BITS), .WINDOW(WINDOW)) u_win_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc && !opcode && channel),
		.wr_data (sample),
		.sum     (sum_i)
	);

	// a report snapshots both sums, so later samples cannot leak into it
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sum_n_s1 <= sum_n;
			sum_i_s1 <= sum_i;
		end
	end

	logic          flt_n_s3, flt_i_s3;
	logic [MW-1:0] map_n_s3, map_i_s3;

	rpsc_chan #(.ADC_BITS(ADC_BITS), .WINDOW(WINDOW)) u_chan_n (
		.clk       (clk),
		.ctl       (ctl),
		.sum_s1    (sum_n_s1),
		.span_lo   (norm_lo_q),
		.span_hi   (norm_hi_q),
		.gain      (norm_gn_q),
		.fault_lo  (fault_lo_q),
		.fault_hi  (fault_hi_q),
		.fault_s3  (flt_n_s3),
		.mapped_s3 (map_n_s3)
	);

	rpsc_chan #(.ADC_BITS(ADC_BITS), .WINDOW(WINDOW)) u_chan_i (
		.clk       (clk),
		.ctl       (ctl),
		.sum_s1    (sum_i_s1),
		.span_lo   (inv_lo_q),
		.span_hi   (inv_hi_q),
		.gain      (inv_gn_q),
		.fault_lo  (fault_lo_q),
		.fault_hi  (fault_hi_q),
		.fault_s3  (flt_i_s3),
		.mapped_s3 (map_i_s3)
	);

	// Final stage: saturate, flip the inverted channel, correlate, combine.
	logic [14:0]        pos_n, sat_i, pos_i, diff;
	logic [15:0]        pos_sum;
	rpsc_pkg::status_t  st;
	logic [14:0]        position_s4;
	rpsc_pkg::status_t  status_s4;

	always_comb begin
		pos_n   = (map_n_s3 > FULL_EXT) ? rpsc_pkg::FULL_SCALE_Q8 : map_n_s3[14:0];
		sat_i   = (map_i_s3 > FULL_EXT) ? rpsc_pkg::FULL_SCALE_Q8 : map_i_s3[14:0];
		pos_i   = rpsc_pkg::FULL_SCALE_Q8 - sat_i;
		diff    = (pos_n > pos_i) ? (pos_n - pos_i) : (pos_i - pos_n);
		pos_sum = {1'b0, pos_n} + {1'b0, pos_i};
		// uncorrelated beats inverted fault beats normal fault
		priority if (diff > rpsc_pkg::CORR_LIMIT_Q8) begin
			st = rpsc_pkg::ST_UNCORR;
		end else if (flt_i_s3) begin
			st = rpsc_pkg::ST_INV_FLT;
		end else if (flt_n_s3) begin
			st = rpsc_pkg::ST_NORM_FLT;
		end else begin
			st = rpsc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			status_s4   <= st;
			position_s4 <= (st == rpsc_pkg::ST_OK) ? pos_sum[15:1] : 15'd0;
		end
	end

	assign out_valid = vld_s4;
	assign position  = position_s4;
	assign status    = status_s4;

endmodule
